### rtl/xbt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xbt_pkg
// Types, codes and the transition table of the XML byte tokenizer.
// ----------------------------------------------------------------------------
package xbt_pkg;

    localparam int NSTATES = 20;
    localparam int NGROUPS = 14;

    typedef logic [4:0] state_code_t;
    typedef logic [3:0] group_t;
    typedef logic signed [7:0] act_t;

    typedef enum logic [2:0] {
        ROLE_MARKUP     = 3'd0,
        ROLE_OPEN_NAME  = 3'd1,
        ROLE_CLOSE_NAME = 3'd2,
        ROLE_ATTR_NAME  = 3'd3,
        ROLE_ATTR_VALUE = 3'd4,
        ROLE_TEXT       = 3'd5
    } role_t;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_OPEN_DONE  = 3'd1,
        EV_SELF_CLOSE = 3'd2,
        EV_CLOSE_DONE = 3'd3,
        EV_ATTR_DONE  = 3'd4,
        EV_TEXT_END   = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_BAD_START = 3'd1,
        ERR_FORBIDDEN = 3'd2,
        ERR_SYNTAX    = 3'd3,
        ERR_NO_EQ     = 3'd4,
        ERR_NUL       = 3'd5
    } error_t;

    // Lexer states.
    localparam state_code_t ST_IDLE        = 5'd0;
    localparam state_code_t ST_PI          = 5'd1;
    localparam state_code_t ST_LT          = 5'd2;
    localparam state_code_t ST_SLASH_END   = 5'd3;
    localparam state_code_t ST_TEXT        = 5'd5;
    localparam state_code_t ST_OPEN_NAME   = 5'd6;
    localparam state_code_t ST_IN_TAG      = 5'd7;
    localparam state_code_t ST_ATTR_NAME   = 5'd8;
    localparam state_code_t ST_ATTR_EQ     = 5'd10;
    localparam state_code_t ST_ATTR_VALUE  = 5'd11;
    localparam state_code_t ST_CLOSE_NAME  = 5'd13;
    localparam state_code_t ST_CLOSE_TAIL  = 5'd14;
    localparam state_code_t ST_ANAME_TAIL  = 5'd15;

    // Character groups.
    localparam group_t G_OTHER  = 4'd0;
    localparam group_t G_SPACE  = 4'd1;
    localparam group_t G_QUOTE  = 4'd2;
    localparam group_t G_LT     = 4'd3;
    localparam group_t G_GT     = 4'd4;
    localparam group_t G_AMP    = 4'd5;
    localparam group_t G_SEMI   = 4'd6;
    localparam group_t G_QMARK  = 4'd7;
    localparam group_t G_SLASH  = 4'd8;
    localparam group_t G_EQ     = 4'd9;
    localparam group_t G_BANG   = 4'd10;
    localparam group_t G_LBRACK = 4'd11;
    localparam group_t G_RBRACK = 4'd12;
    localparam group_t G_NUL    = 4'd13;

    // Table actions: a non-negative entry is a plain move to that state.
    localparam act_t X_SELF_CLOSE   = -8'sd1;
    localparam act_t X_TAG_END      = -8'sd2;
    localparam act_t X_OPEN_NAME    = -8'sd3;
    localparam act_t X_TEXT_END     = -8'sd4;
    localparam act_t X_ATTR_DONE    = -8'sd5;
    localparam act_t X_NAME_END     = -8'sd6;
    localparam act_t X_NAME_WS      = -8'sd7;
    localparam act_t X_ATTR_START   = -8'sd8;
    localparam act_t X_SLASH        = -8'sd9;
    localparam act_t X_EQ           = -8'sd10;
    localparam act_t X_QUOTE_OPEN   = -8'sd11;
    localparam act_t X_ANAME_WS     = -8'sd12;
    localparam act_t X_CLOSE_NAME   = -8'sd13;
    localparam act_t X_CLOSE_WS     = -8'sd14;
    localparam act_t X_CLOSE_END_WS = -8'sd15;
    localparam act_t X_CLOSE_END    = -8'sd16;
    localparam act_t X_CDATA_END    = -8'sd20;
    localparam act_t NUL0           = -8'sd63;
    localparam act_t BADS           = -8'sd65;
    localparam act_t FORB           = -8'sd66;
    localparam act_t SYNX           = -8'sd67;
    localparam act_t NOEQ           = -8'sd69;

    localparam act_t TRANS [NSTATES][NGROUPS] = '{
        '{BADS, 8'sd0, BADS, 8'sd1, BADS, BADS, BADS,
          BADS, BADS, BADS, SYNX, BADS, BADS, NUL0},
        '{BADS, BADS, BADS, BADS, BADS, BADS, BADS,
          8'sd9, BADS, BADS, SYNX, BADS, BADS, NUL0},
        '{X_OPEN_NAME, 8'sd2, SYNX, FORB, FORB, FORB, FORB,
          FORB, 8'sd12, FORB, 8'sd16, FORB, FORB, NUL0},
        '{SYNX, SYNX, SYNX, SYNX, X_SELF_CLOSE, SYNX, SYNX,
          SYNX, SYNX, BADS, SYNX, SYNX, SYNX, NUL0},
        '{SYNX, SYNX, SYNX, SYNX, X_TAG_END, SYNX, SYNX,
          SYNX, SYNX, BADS, BADS, SYNX, SYNX, NUL0},
        '{8'sd5, 8'sd5, 8'sd5, X_TEXT_END, 8'sd5, 8'sd5, 8'sd5,
          8'sd5, 8'sd5, 8'sd5, 8'sd5, SYNX, SYNX, NUL0},
        '{8'sd6, X_NAME_WS, SYNX, FORB, X_NAME_END, FORB, FORB,
          SYNX, X_SLASH, SYNX, SYNX, SYNX, SYNX, NUL0},
        '{X_ATTR_START, 8'sd7, SYNX, FORB, X_TAG_END, FORB, FORB,
          8'sd7, 8'sd3, SYNX, SYNX, SYNX, SYNX, NUL0},
        '{8'sd8, X_ANAME_WS, SYNX, FORB, SYNX, FORB, FORB,
          SYNX, SYNX, X_EQ, SYNX, SYNX, SYNX, NUL0},
        '{8'sd9, 8'sd7, SYNX, SYNX, SYNX, SYNX, SYNX,
          SYNX, SYNX, SYNX, SYNX, SYNX, SYNX, NUL0},
        '{NOEQ, 8'sd10, X_QUOTE_OPEN, NOEQ, NOEQ, NOEQ, NOEQ,
          NOEQ, NOEQ, NOEQ, SYNX, SYNX, SYNX, NUL0},
        '{8'sd11, 8'sd11, X_ATTR_DONE, 8'sd11, 8'sd11, 8'sd11, 8'sd11,
          8'sd11, 8'sd11, 8'sd11, SYNX, SYNX, SYNX, NUL0},
        '{X_CLOSE_NAME, 8'sd12, SYNX, SYNX, SYNX, SYNX, SYNX,
          SYNX, SYNX, SYNX, SYNX, SYNX, SYNX, NUL0},
        '{8'sd13, X_CLOSE_WS, SYNX, SYNX, X_CLOSE_END, SYNX, SYNX,
          SYNX, SYNX, SYNX, SYNX, SYNX, SYNX, NUL0},
        '{SYNX, 8'sd14, SYNX, SYNX, X_CLOSE_END_WS, SYNX, SYNX,
          SYNX, SYNX, SYNX, SYNX, SYNX, SYNX, NUL0},
        '{SYNX, 8'sd15, SYNX, FORB, SYNX, SYNX, SYNX,
          SYNX, SYNX, 8'sd10, SYNX, SYNX, SYNX, NUL0},
        '{SYNX, SYNX, SYNX, FORB, SYNX, SYNX, SYNX,
          SYNX, SYNX, SYNX, SYNX, 8'sd17, SYNX, NUL0},
        '{8'sd17, SYNX, SYNX, SYNX, SYNX, SYNX, SYNX,
          SYNX, SYNX, SYNX, SYNX, 8'sd18, SYNX, NUL0},
        '{8'sd18, 8'sd18, 8'sd18, 8'sd18, 8'sd18, 8'sd18, 8'sd18,
          8'sd18, 8'sd18, 8'sd18, 8'sd18, 8'sd18, 8'sd19, NUL0},
        '{8'sd18, 8'sd18, 8'sd18, 8'sd18, X_CDATA_END, 8'sd18, 8'sd18,
          8'sd18, 8'sd18, 8'sd18, 8'sd18, 8'sd18, 8'sd19, NUL0}
    };

    typedef struct packed {
        state_code_t lexer_state;
        logic        in_prolog;
        logic        text_capturing;
        error_t      error_latch;
    } lex_state_t;

    typedef struct packed {
        role_t  role;
        event_t ev;
        error_t err;
    } lex_result_t;

    localparam lex_state_t LEX_RESET = '{
        lexer_state:    ST_IDLE,
        in_prolog:      1'b1,
        text_capturing: 1'b0,
        error_latch:    ERR_OK
    };

    function automatic group_t char_group(input logic [7:0] b);
        group_t g;
        case (b)
            8'h00:                      g = G_NUL;
            8'h09, 8'h0a, 8'h0d, 8'h20: g = G_SPACE;
            8'h22:                      g = G_QUOTE;
            8'h3c:                      g = G_LT;
            8'h3e:                      g = G_GT;
            8'h26:                      g = G_AMP;
            8'h3b:                      g = G_SEMI;
            8'h3f:                      g = G_QMARK;
            8'h2f:                      g = G_SLASH;
            8'h3d:                      g = G_EQ;
            8'h21:                      g = G_BANG;
            8'h5b:                      g = G_LBRACK;
            8'h5d:                      g = G_RBRACK;
            default:                    g = G_OTHER;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

### rtl/xbt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xbt_if
// Valid/ready channels of the tokenizer: raw bytes in, classified bytes out.
// ----------------------------------------------------------------------------
interface xbt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface xbt_token_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [2:0] role;
    logic [2:0] event_res;
    logic [2:0] error_code;

    modport source (output valid, output byte_out, output role, output event_res,
                    output error_code, input ready);
    modport sink   (input valid, input byte_out, input role, input event_res,
                    input error_code, output ready);
endinterface
`default_nettype wire

### rtl/xml_byte_tokenizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xml_byte_tokenizer_unit
// Byte-serial XML tokenizer: tags each byte with a role, event and error code.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  bytes     in    valid/ready    byte_in
//  tokens    out   valid/ready    byte_out, role, event_res, error_code
//
//  One item per cycle sustained while tokens.ready holds; an accepted item goes
//  from the input register through the single table transition to the result register.
//  The lexer state advances only when an item moves into the result register.
//  A stalled result holds in place while the input register still takes one
//  more item. Reset clears the lexer to its start state and the prolog mode.
// ----------------------------------------------------------------------------
module xml_byte_tokenizer_unit
    import xbt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    xbt_byte_if.sink     bytes,
    xbt_token_if.source  tokens
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    lex_result_t out_res_reg;
    lex_state_t  state_reg;
    lex_state_t  state_next;
    lex_result_t res_next;
    logic        advance;
    logic        take;

    xbt_step u_step (
        .byte_in (in_byte_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || tokens.ready);
    assign bytes.ready  = !in_valid_reg || advance;
    assign take         = bytes.valid && bytes.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= LEX_RESET;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (tokens.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= bytes.byte_in;
        end
        if (advance)
        begin
            out_byte_reg <= in_byte_reg;
            out_res_reg  <= res_next;
        end
    end

    assign tokens.valid      = out_valid_reg;
    assign tokens.byte_out   = out_byte_reg;
    assign tokens.role       = out_res_reg.role;
    assign tokens.event_res  = out_res_reg.ev;
    assign tokens.error_code = out_res_reg.err;

endmodule
`default_nettype wire

### rtl/xbt_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xbt_step
// One lexer transition: byte classification, table lookup and action decode.
// ----------------------------------------------------------------------------
module xbt_step
    import xbt_pkg::*;
(
    input  wire logic [7:0] byte_in,
    input  wire lex_state_t cur,
    output lex_state_t      nxt,
    output lex_result_t     res
);

    group_t      grp;
    act_t        act;
    state_code_t target;
    error_t      err;

    assign grp = char_group(byte_in);

    always_comb
    begin
        nxt      = cur;
        res.role = ROLE_MARKUP;
        res.ev   = EV_NONE;
        err      = ERR_OK;
        target   = cur.lexer_state;
        act      = SYNX;

        if (cur.error_latch == ERR_OK)
        begin
            if (cur.lexer_state < state_code_t'(NSTATES))
            begin
                act = TRANS[cur.lexer_state][grp];
            end

            if (act >= 0)
            begin
                target = act[4:0];
                // A byte that keeps the lexer where it is belongs to the token.
                if (target == cur.lexer_state)
                begin
                    case (cur.lexer_state)
                        ST_OPEN_NAME:  res.role = ROLE_OPEN_NAME;
                        ST_CLOSE_NAME: res.role = ROLE_CLOSE_NAME;
                        ST_ATTR_NAME:  res.role = ROLE_ATTR_NAME;
                        ST_ATTR_VALUE: res.role = ROLE_ATTR_VALUE;
                        ST_TEXT:
                        begin
                            if (cur.text_capturing)
                            begin
                                res.role = ROLE_TEXT;
                            end
                        end
                        default:       res.role = ROLE_MARKUP;
                    endcase
                end
            end
            else
            begin
                case (act)
                    X_SELF_CLOSE:
                    begin
                        res.ev = EV_SELF_CLOSE;
                        nxt.text_capturing = 1'b1;
                        target = ST_TEXT;
                    end
                    X_TAG_END, X_NAME_END:
                    begin
                        res.ev = EV_OPEN_DONE;
                        nxt.text_capturing = 1'b1;
                        target = ST_TEXT;
                    end
                    X_OPEN_NAME:
                    begin
                        nxt.in_prolog = 1'b0;
                        res.role = ROLE_OPEN_NAME;
                        target = ST_OPEN_NAME;
                    end
                    X_CLOSE_NAME:
                    begin
                        nxt.in_prolog = 1'b0;
                        res.role = ROLE_CLOSE_NAME;
                        target = ST_CLOSE_NAME;
                    end
                    X_CLOSE_WS:    target = ST_CLOSE_TAIL;
                    X_CLOSE_END_WS, X_CLOSE_END:
                    begin
                        res.ev = EV_CLOSE_DONE;
                        nxt.text_capturing = 1'b1;
                        target = ST_TEXT;
                    end
                    X_TEXT_END:
                    begin
                        res.ev = EV_TEXT_END;
                        nxt.text_capturing = 1'b0;
                        target = ST_LT;
                    end
                    X_NAME_WS:     target = ST_IN_TAG;
                    X_ATTR_START:
                    begin
                        res.role = ROLE_ATTR_NAME;
                        target = ST_ATTR_NAME;
                    end
                    X_SLASH:       target = ST_SLASH_END;
                    X_ANAME_WS:    target = ST_ANAME_TAIL;
                    X_EQ:          target = ST_ATTR_EQ;
                    X_QUOTE_OPEN:  target = ST_ATTR_VALUE;
                    X_ATTR_DONE:
                    begin
                        res.ev = EV_ATTR_DONE;
                        target = ST_IN_TAG;
                    end
                    X_CDATA_END:   target = ST_TEXT;
                    BADS:          err = ERR_BAD_START;
                    FORB:          err = ERR_FORBIDDEN;
                    NOEQ:          err = ERR_NO_EQ;
                    NUL0:          err = ERR_NUL;
                    default:       err = ERR_SYNTAX;
                endcase
            end

            if (err != ERR_OK)
            begin
                nxt.error_latch = err;
                res.role = ROLE_MARKUP;
                res.ev   = EV_NONE;
            end
            else
            begin
                nxt.lexer_state = target;
            end

            if (nxt.in_prolog)
            begin
                res.role = ROLE_MARKUP;
                res.ev   = EV_NONE;
            end
        end

        res.err = nxt.error_latch;
    end

endmodule
`default_nettype wire

### tb/tb_xml_byte_tokenizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_xml_byte_tokenizer_unit
// Self-checking bench for the byte-serial XML tokenizer. A behavioral copy of
// the lexer predicts role, event and error code for every accepted byte. The
// stimulus is a short hand-written document, then randomly built markup (tags,
// attributes, text and CDATA), and last one error chosen at random, followed by
// bytes that must come back frozen. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_xml_byte_tokenizer_unit;
    import xbt_pkg::*;

    localparam int ITEMS_TARGET = 750;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] value;
        role_t      role;
        event_t     ev;
        error_t     err;
    } token_t;

    typedef enum int {FLOW_STEADY, FLOW_LIGHT, FLOW_HEAVY} flow_t;

    // Character groups that may not appear in each kind of random content.
    localparam logic [15:0] NAME_BAN  = ~(16'd1 << G_OTHER);
    localparam logic [15:0] VALUE_BAN = (16'd1 << G_QUOTE) | (16'd1 << G_BANG)
                                      | (16'd1 << G_LBRACK) | (16'd1 << G_RBRACK)
                                      | (16'd1 << G_NUL);
    localparam logic [15:0] TEXT_BAN  = (16'd1 << G_LT) | (16'd1 << G_LBRACK)
                                      | (16'd1 << G_RBRACK) | (16'd1 << G_NUL);
    localparam logic [15:0] CDATA_BAN = 16'd1 << G_NUL;

    localparam logic [7:0] SPACE_BYTES [4] = '{8'h09, 8'h0a, 8'h0d, 8'h20};

    // Lexer transitions: a non-negative entry moves to that state, a negative
    // one names an action or an error.
    localparam int LEX_TABLE [NSTATES][NGROUPS] = '{
        '{BADS, 0, BADS, 1, BADS, BADS, BADS,
          BADS, BADS, BADS, SYNX, BADS, BADS, NUL0},
        '{BADS, BADS, BADS, BADS, BADS, BADS, BADS,
          9, BADS, BADS, SYNX, BADS, BADS, NUL0},
        '{X_OPEN_NAME, 2, SYNX, FORB, FORB, FORB, FORB,
          FORB, 12, FORB, 16, FORB, FORB, NUL0},
        '{SYNX, SYNX, SYNX, SYNX, X_SELF_CLOSE, SYNX, SYNX,
          SYNX, SYNX, BADS, SYNX, SYNX, SYNX, NUL0},
        '{SYNX, SYNX, SYNX, SYNX, X_TAG_END, SYNX, SYNX,
          SYNX, SYNX, BADS, BADS, SYNX, SYNX, NUL0},
        '{5, 5, 5, X_TEXT_END, 5, 5, 5,
          5, 5, 5, 5, SYNX, SYNX, NUL0},
        '{6, X_NAME_WS, SYNX, FORB, X_NAME_END, FORB, FORB,
          SYNX, X_SLASH, SYNX, SYNX, SYNX, SYNX, NUL0},
        '{X_ATTR_START, 7, SYNX, FORB, X_TAG_END, FORB, FORB,
          7, 3, SYNX, SYNX, SYNX, SYNX, NUL0},
        '{8, X_ANAME_WS, SYNX, FORB, SYNX, FORB, FORB,
          SYNX, SYNX, X_EQ, SYNX, SYNX, SYNX, NUL0},
        '{9, 7, SYNX, SYNX, SYNX, SYNX, SYNX,
          SYNX, SYNX, SYNX, SYNX, SYNX, SYNX, NUL0},
        '{NOEQ, 10, X_QUOTE_OPEN, NOEQ, NOEQ, NOEQ, NOEQ,
          NOEQ, NOEQ, NOEQ, SYNX, SYNX, SYNX, NUL0},
        '{11, 11, X_ATTR_DONE, 11, 11, 11, 11,
          11, 11, 11, SYNX, SYNX, SYNX, NUL0},
        '{X_CLOSE_NAME, 12, SYNX, SYNX, SYNX, SYNX, SYNX,
          SYNX, SYNX, SYNX, SYNX, SYNX, SYNX, NUL0},
        '{13, X_CLOSE_WS, SYNX, SYNX, X_CLOSE_END, SYNX, SYNX,
          SYNX, SYNX, SYNX, SYNX, SYNX, SYNX, NUL0},
        '{SYNX, 14, SYNX, SYNX, X_CLOSE_END_WS, SYNX, SYNX,
          SYNX, SYNX, SYNX, SYNX, SYNX, SYNX, NUL0},
        '{SYNX, 15, SYNX, FORB, SYNX, SYNX, SYNX,
          SYNX, SYNX, 10, SYNX, SYNX, SYNX, NUL0},
        '{SYNX, SYNX, SYNX, FORB, SYNX, SYNX, SYNX,
          SYNX, SYNX, SYNX, SYNX, 17, SYNX, NUL0},
        '{17, SYNX, SYNX, SYNX, SYNX, SYNX, SYNX,
          SYNX, SYNX, SYNX, SYNX, 18, SYNX, NUL0},
        '{18, 18, 18, 18, 18, 18, 18,
          18, 18, 18, 18, 18, 19, NUL0},
        '{18, 18, 18, 18, X_CDATA_END, 18, 18,
          18, 18, 18, 18, 18, 19, NUL0}
    };

    logic clk = 1'b0;
    logic rst_n;

    xbt_byte_if  byte_ch ();
    xbt_token_if token_ch ();

    xml_byte_tokenizer_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (byte_ch),
        .tokens (token_ch)
    );

    // Predicted lexer state.
    state_code_t tok_state  = ST_IDLE;
    logic        tok_prolog = 1'b1;
    logic        tok_text   = 1'b0;
    error_t      tok_fault  = ERR_OK;

    token_t pending_tokens [$];
    int     bytes_sent       = 0;
    int     tokens_seen      = 0;
    int     token_mismatches = 0;
    int     cycle_count      = 0;
    int     burst_left       = 0;
    int     stall_left       = 0;
    flow_t  send_flow        = FLOW_STEADY;
    flow_t  recv_flow        = FLOW_STEADY;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic group_t byte_group(input logic [7:0] b);
        case (b)
            8'h00:                      return G_NUL;
            8'h09, 8'h0a, 8'h0d, 8'h20: return G_SPACE;
            "\"":                       return G_QUOTE;
            "<":                        return G_LT;
            ">":                        return G_GT;
            "&":                        return G_AMP;
            ";":                        return G_SEMI;
            "?":                        return G_QMARK;
            "/":                        return G_SLASH;
            "=":                        return G_EQ;
            "!":                        return G_BANG;
            "[":                        return G_LBRACK;
            "]":                        return G_RBRACK;
            default:                    return G_OTHER;
        endcase
    endfunction

    // Classifies one byte and advances the predicted lexer.
    function automatic token_t tokenize_byte(input logic [7:0] b);
        token_t      t;
        int          act;
        state_code_t nxt;
        error_t      fault;
        t.value = b;
        t.role  = ROLE_MARKUP;
        t.ev    = EV_NONE;
        t.err   = tok_fault;
        if (tok_fault != ERR_OK)
            return t;
        fault = ERR_OK;
        nxt   = tok_state;
        act   = (tok_state < NSTATES) ? LEX_TABLE[tok_state][byte_group(b)] : int'(SYNX);
        if (act >= 0)
        begin
            nxt = act[4:0];
            if (nxt == tok_state)
            begin
                case (tok_state)
                    ST_OPEN_NAME:  t.role = ROLE_OPEN_NAME;
                    ST_CLOSE_NAME: t.role = ROLE_CLOSE_NAME;
                    ST_ATTR_NAME:  t.role = ROLE_ATTR_NAME;
                    ST_ATTR_VALUE: t.role = ROLE_ATTR_VALUE;
                    ST_TEXT:       if (tok_text) t.role = ROLE_TEXT;
                    default:       ;
                endcase
            end
        end
        else
        begin
            case (act)
                X_SELF_CLOSE:
                begin
                    t.ev = EV_SELF_CLOSE;
                    tok_text = 1'b1;
                    nxt = ST_TEXT;
                end
                X_TAG_END, X_NAME_END:
                begin
                    t.ev = EV_OPEN_DONE;
                    tok_text = 1'b1;
                    nxt = ST_TEXT;
                end
                X_OPEN_NAME:
                begin
                    tok_prolog = 1'b0;
                    t.role = ROLE_OPEN_NAME;
                    nxt = ST_OPEN_NAME;
                end
                X_CLOSE_NAME:
                begin
                    tok_prolog = 1'b0;
                    t.role = ROLE_CLOSE_NAME;
                    nxt = ST_CLOSE_NAME;
                end
                X_CLOSE_WS:  nxt = ST_CLOSE_TAIL;
                X_CLOSE_END_WS, X_CLOSE_END:
                begin
                    t.ev = EV_CLOSE_DONE;
                    tok_text = 1'b1;
                    nxt = ST_TEXT;
                end
                X_TEXT_END:
                begin
                    t.ev = EV_TEXT_END;
                    tok_text = 1'b0;
                    nxt = ST_LT;
                end
                X_NAME_WS:   nxt = ST_IN_TAG;
                X_ATTR_START:
                begin
                    t.role = ROLE_ATTR_NAME;
                    nxt = ST_ATTR_NAME;
                end
                X_SLASH:      nxt = ST_SLASH_END;
                X_ANAME_WS:   nxt = ST_ANAME_TAIL;
                X_EQ:         nxt = ST_ATTR_EQ;
                X_QUOTE_OPEN: nxt = ST_ATTR_VALUE;
                X_ATTR_DONE:
                begin
                    t.ev = EV_ATTR_DONE;
                    nxt = ST_IN_TAG;
                end
                X_CDATA_END:  nxt = ST_TEXT;
                BADS:         fault = ERR_BAD_START;
                FORB:         fault = ERR_FORBIDDEN;
                NOEQ:         fault = ERR_NO_EQ;
                NUL0:         fault = ERR_NUL;
                default:      fault = ERR_SYNTAX;
            endcase
        end
        if (fault != ERR_OK)
        begin
            tok_fault = fault;
            t.role = ROLE_MARKUP;
            t.ev = EV_NONE;
        end
        else
        begin
            tok_state = nxt;
        end
        if (tok_prolog)
        begin
            t.role = ROLE_MARKUP;
            t.ev = EV_NONE;
        end
        t.err = tok_fault;
        return t;
    endfunction

    function automatic logic [7:0] pick_byte(input logic [15:0] banned);
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (banned[byte_group(b)]);
        return b;
    endfunction

    // Sends one byte; a new burst may start with an idle gap on the channel.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            case (send_flow)
                FLOW_LIGHT: gap = $urandom_range(0, 2);
                FLOW_HEAVY: gap = $urandom_range(1, 8);
                default:    gap = 0;
            endcase
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        byte_ch.valid   <= 1'b1;
        byte_ch.byte_in <= b;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        pending_tokens.push_back(tokenize_byte(b));
        bytes_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_spaces(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) send_byte(SPACE_BYTES[$urandom_range(0, 3)]);
    endtask

    task automatic send_name();
        repeat ($urandom_range(1, 4)) send_byte(pick_byte(NAME_BAN));
    endtask

    task automatic emit_open_tag();
        int attrs;
        attrs = $urandom_range(0, 3);
        send_byte("<");
        send_spaces(0, 1);
        send_name();
        if (attrs > 0)
            send_spaces(1, 2);
        else
            send_spaces(0, 1);
        repeat (attrs)
        begin
            send_name();
            send_spaces(0, 1);
            send_byte("=");
            send_spaces(0, 1);
            send_byte("\"");
            repeat ($urandom_range(0, 5)) send_byte(pick_byte(VALUE_BAN));
            send_byte("\"");
            send_spaces(0, 1);
            if ($urandom_range(0, 7) == 0)
                send_byte("?");
        end
        if ($urandom_range(0, 2) == 0)
            send_byte("/");
        send_byte(">");
    endtask

    task automatic emit_close_tag();
        send_byte("<");
        send_spaces(0, 1);
        send_byte("/");
        send_spaces(0, 1);
        send_name();
        send_spaces(0, 1);
        send_byte(">");
    endtask

    task automatic emit_text();
        repeat ($urandom_range(1, 6)) send_byte(pick_byte(TEXT_BAN));
    endtask

    task automatic emit_cdata();
        logic [7:0] b;
        logic [7:0] prev;
        prev = 8'h00;
        send_byte("<");
        send_spaces(0, 1);
        send_str("![");
        if ($urandom_range(0, 1) == 1)
            send_str("CDATA");
        else
            repeat ($urandom_range(0, 5)) send_byte(pick_byte(NAME_BAN));
        send_byte("[");
        // A '>' right after a ']' would close the section early.
        repeat ($urandom_range(0, 6))
        begin
            do
                b = pick_byte(CDATA_BAN);
            while (prev == "]" && b == ">");
            send_byte(b);
            prev = b;
        end
        send_str("]]>");
    endtask

    task automatic test_directed_document();
        send_flow = FLOW_LIGHT;
        recv_flow = FLOW_LIGHT;
        send_str(" <? ?>");
        send_str("<a b=\"");
        send_byte(8'hff);
        send_str("\"/>");
        send_byte(8'h80);
        send_str("</a >");
        send_str("<c>");
    endtask

    task automatic test_random_documents();
        int pick;
        int phase_end;
        int phase;
        phase_end = 0;
        phase = 0;
        while (bytes_sent < ITEMS_TARGET)
        begin
            if (bytes_sent >= phase_end)
            begin
                // The first phase runs with neither side idling.
                send_flow = (phase == 0) ? FLOW_STEADY : flow_t'($urandom_range(0, 2));
                recv_flow = (phase == 0) ? FLOW_STEADY : flow_t'($urandom_range(0, 2));
                phase_end = bytes_sent + $urandom_range(60, 160);
                phase++;
            end
            pick = $urandom_range(0, 9);
            if (pick < 3)
                emit_open_tag();
            else if (pick < 5)
                emit_close_tag();
            else if (pick < 8)
                emit_text();
            else
                emit_cdata();
        end
    endtask

    // The error latch only clears on reset, so a single fault ends the document.
    task automatic test_error_freeze();
        error_t kind;
        kind = error_t'($urandom_range(ERR_BAD_START, ERR_NUL));
        send_flow = FLOW_LIGHT;
        recv_flow = FLOW_HEAVY;
        case (kind)
            ERR_BAD_START: send_str("<a/=");
            ERR_FORBIDDEN: send_str("<a<");
            ERR_SYNTAX:    send_byte("[");
            ERR_NO_EQ:     send_str("<a b=x");
            default:       send_byte(8'h00);
        endcase
        send_byte(8'h00);
        send_byte(8'hff);
        repeat (12) send_byte(8'($urandom));
    endtask

    // Receiver stall pattern.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            token_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            token_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            token_ch.ready <= 1'b1;
            case (recv_flow)
                FLOW_LIGHT: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 2);
                FLOW_HEAVY: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 8);
                default:    ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && token_ch.valid && token_ch.ready)
        begin
            tokens_seen++;
            if (pending_tokens.size() == 0)
            begin
                token_mismatches++;
                if (token_mismatches <= REPORT_LIMIT)
                    $display("token %0d: byte %02h arrived with nothing expected",
                             tokens_seen, token_ch.byte_out);
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (token_ch.byte_out !== want.value || token_ch.role !== want.role ||
                    token_ch.event_res !== want.ev || token_ch.error_code !== want.err)
                begin
                    token_mismatches++;
                    if (token_mismatches <= REPORT_LIMIT)
                    begin
                        $display("token %0d: expected byte %02h role %0d event %0d error %0d",
                                 tokens_seen, want.value, want.role, want.ev, want.err);
                        $display("token %0d: got byte %02h role %0d event %0d error %0d",
                                 tokens_seen, token_ch.byte_out, token_ch.role,
                                 token_ch.event_res, token_ch.error_code);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL xml_byte_tokenizer_unit");
            $finish;
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.byte_in <= 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_document();
        test_random_documents();
        test_error_freeze();

        byte_ch.valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (token_mismatches == 0 && pending_tokens.size() == 0)
            $display("PASS xml_byte_tokenizer_unit");
        else
            $display("FAIL xml_byte_tokenizer_unit");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
rtl/xbt_pkg.sv
rtl/xbt_if.sv
rtl/xbt_step.sv
rtl/xml_byte_tokenizer_unit.sv
tb/tb_xml_byte_tokenizer_unit.sv
